// ----- rtl/sdo_block_upload_server_unit_assert.svh -----
// Assertion macros used by the block upload server checker.
`ifndef SDO_BLOCK_UPLOAD_SERVER_UNIT_ASSERT_SVH
`define SDO_BLOCK_UPLOAD_SERVER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define SDOBU_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdobu: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define SDOBU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdobu: next-cycle check failed");

`endif

// ----- rtl/sdobu_pkg.sv -----
// Types and constants of the block upload server.
package sdobu_pkg;

  localparam int unsigned SEGMENT_BYTES = 7;
  localparam int unsigned MAX_SEQ       = 127;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] SEG_LEN = 4'(SEGMENT_BYTES);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_READY     = 3'd1,
    PH_SENDING   = 3'd2,
    PH_AWAIT_ACK = 3'd3,
    PH_ENDING    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    FK_NONE    = 3'd0,
    FK_INIT    = 3'd1,
    FK_SEGMENT = 3'd2,
    FK_END     = 3'd3,
    FK_ABORT   = 3'd4
  } frame_kind_t;

  typedef enum logic [2:0] {
    AR_NONE        = 3'd0,
    AR_BAD_CMD     = 3'd1,
    AR_BAD_BLKSIZE = 3'd2,
    AR_BAD_SEQ     = 3'd3,
    AR_OBJECT      = 3'd4
  } abort_reason_t;

  typedef enum logic [1:0] {
    SUB_INITIATE = 2'd0,
    SUB_END      = 2'd1,
    SUB_RESPONSE = 2'd2,
    SUB_START    = 2'd3
  } subcmd_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SEGMENT,
    ACT_INIT,
    ACT_START,
    ACT_END,
    ACT_RESTART,
    ACT_FINISH,
    ACT_ABORT
  } action_t;

  // One classified transaction as it waits in the queue.
  typedef struct packed {
    logic        tick;
    subcmd_t     sub;
    logic        blksize_ok;
    logic [6:0]  blksize;
    logic [7:0]  ack;
    logic        crc;
    logic [3:0]  obj_status;
    logic [31:0] obj_size;
    logic [3:0]  rd_status;
  } cmd_t;

  typedef struct packed {
    frame_kind_t   kind;
    logic [6:0]    seq;
    logic          last;
    logic [31:0]   offset;
    logic [2:0]    length;
    logic [2:0]    unused;
    logic          crc_on;
    logic [31:0]   size;
    abort_reason_t reason;
    logic [3:0]    obj_err;
    logic          finished;
  } res_t;

endpackage

// ----- rtl/sdo_block_upload_server_unit.sv -----
// Block upload server: top level joining front end, queue and back end.
//
// Input channel (in_valid/in_ready) carries one transaction per item: either
// a decoded client frame (func = 0) or a transmit tick (func = 1). Output
// channel (out_valid/out_ready) returns exactly one result per input item,
// in order; frame_kind 0 means the item produced nothing to send.
// A result is registered twice after its input is accepted: the input is
// written into a queue entry, then the back end steps it into the result
// register. Throughput: one item per cycle while out_ready stays high; the
// back end works out each result combinationally from the queue head.
// A four-entry queue separates the front end from the back end, so input is
// still taken while a result waits; in_ready drops only when the queue is
// full.
// Reset (rst, synchronous) empties the queue, drops out_valid and
// puts the transfer in the idle phase with sequence number one.
module sdo_block_upload_server_unit import sdobu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [1:0]  client_subcommand,
  input  logic [7:0]  block_size,
  input  logic [7:0]  ack_sequence,
  input  logic        crc_supported,
  input  logic [3:0]  object_status,
  input  logic [31:0] object_size,
  input  logic [3:0]  read_status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  frame_kind,
  output logic [6:0]  sequence_res,
  output logic        last_segment,
  output logic [31:0] data_offset,
  output logic [2:0]  data_length,
  output logic [2:0]  unused_bytes,
  output logic        crc_on,
  output logic [31:0] transfer_size,
  output logic [2:0]  abort_reason,
  output logic [3:0]  object_error,
  output logic        finished
);

  logic q_full;
  logic q_valid;
  logic push;
  logic pop;
  cmd_t cmd;
  cmd_t q_head;
  res_t res;

  sdobu_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .func              (func),
    .client_subcommand (client_subcommand),
    .block_size        (block_size),
    .ack_sequence      (ack_sequence),
    .crc_supported     (crc_supported),
    .object_status     (object_status),
    .object_size       (object_size),
    .read_status       (read_status),
    .q_full            (q_full),
    .push              (push),
    .cmd               (cmd)
  );

  sdobu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  sdobu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res       (res)
  );

  assign frame_kind    = res.kind;
  assign sequence_res  = res.seq;
  assign last_segment  = res.last;
  assign data_offset   = res.offset;
  assign data_length   = res.length;
  assign unused_bytes  = res.unused;
  assign crc_on        = res.crc_on;
  assign transfer_size = res.size;
  assign abort_reason  = res.reason;
  assign object_error  = res.obj_err;
  assign finished      = res.finished;

endmodule

// ----- rtl/sdobu_front.sv -----
// Front end: accepts input transactions and classifies them for the queue.
module sdobu_front import sdobu_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [1:0]  client_subcommand,
  input  logic [7:0]  block_size,
  input  logic [7:0]  ack_sequence,
  input  logic        crc_supported,
  input  logic [3:0]  object_status,
  input  logic [31:0] object_size,
  input  logic [3:0]  read_status,
  input  logic        q_full,
  output logic        push,
  output cmd_t        cmd
);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cmd.tick       = func;
    cmd.sub        = subcmd_t'(client_subcommand);
    cmd.blksize_ok = (block_size != 8'd0) && (block_size <= 8'(MAX_SEQ));
    cmd.blksize    = block_size[6:0];
    cmd.ack        = ack_sequence;
    cmd.crc        = crc_supported;
    cmd.obj_status = object_status;
    cmd.obj_size   = object_size;
    cmd.rd_status  = read_status;
  end

endmodule

// ----- rtl/sdobu_queue.sv -----
// Short queue of classified transactions between front end and back end.
module sdobu_queue import sdobu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic valid,
  output cmd_t head
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic [QPTR_W:0]   count_next;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + (QPTR_W+1)'(1);
      2'b01:   count_next = count - (QPTR_W+1)'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

// ----- rtl/sdobu_back.sv -----
// Back end: transfer state machine, segment arithmetic and result register.
module sdobu_back import sdobu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_head,
  output logic pop,
  input  logic out_ready,
  output logic out_valid,
  output res_t res
);

  phase_t      phase, phase_next;
  logic [31:0] total_size, total_size_next;
  logic [31:0] next_offset, next_offset_next;
  logic [31:0] block_base, block_base_next;
  logic [6:0]  seq_number, seq_number_next;
  logic [6:0]  segs_per_block, segs_per_block_next;
  logic        final_sent, final_sent_next;
  logic        crc_flag, crc_flag_next;
  logic [3:0]  last_len;
  res_t        res_next;

  action_t       act;
  abort_reason_t ab_reason;
  logic [3:0]    ab_err;

  logic [31:0] remaining;
  logic [3:0]  seg_len;
  logic        seg_last;
  logic [31:0] off_after;
  logic [11:0] ack_bytes;
  logic [31:0] restart_offset;

  assign pop = q_valid && (!out_valid || out_ready);

  // Segment length and last flag; the segment is last exactly when what
  // remains fits in one segment, and then the offset lands on the size.
  assign remaining      = total_size - next_offset;
  assign seg_len        = (remaining < 32'(SEGMENT_BYTES)) ? remaining[3:0] : SEG_LEN;
  assign seg_last       = (remaining <= 32'(SEGMENT_BYTES));
  assign off_after      = seg_last ? total_size : next_offset + 32'(SEGMENT_BYTES);
  assign ack_bytes      = {4'b0, q_head.ack} * 12'(SEGMENT_BYTES);
  assign restart_offset = block_base + {20'b0, ack_bytes};

  always_comb begin
    act       = ACT_NONE;
    ab_reason = AR_NONE;
    ab_err    = '0;
    if (q_head.tick) begin
      if (phase == PH_SENDING) begin
        if (q_head.rd_status != 4'd0) begin
          act       = ACT_ABORT;
          ab_reason = AR_OBJECT;
          ab_err    = q_head.rd_status;
        end else begin
          act = ACT_SEGMENT;
        end
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          if (q_head.sub != SUB_INITIATE) begin
            act       = ACT_ABORT;
            ab_reason = AR_BAD_CMD;
          end else if (q_head.obj_status != 4'd0) begin
            act       = ACT_ABORT;
            ab_reason = AR_OBJECT;
            ab_err    = q_head.obj_status;
          end else if (!q_head.blksize_ok) begin
            act       = ACT_ABORT;
            ab_reason = AR_BAD_BLKSIZE;
          end else begin
            act = ACT_INIT;
          end
        end
        PH_READY: begin
          if (q_head.sub != SUB_START) begin
            act       = ACT_ABORT;
            ab_reason = AR_BAD_CMD;
          end else begin
            act = ACT_START;
          end
        end
        PH_AWAIT_ACK: begin
          if (q_head.sub != SUB_RESPONSE) begin
            act       = ACT_ABORT;
            ab_reason = AR_BAD_CMD;
          end else if (!q_head.blksize_ok) begin
            act       = ACT_ABORT;
            ab_reason = AR_BAD_BLKSIZE;
          end else if (q_head.ack > {1'b0, seq_number}) begin
            act       = ACT_ABORT;
            ab_reason = AR_BAD_SEQ;
          end else if (q_head.ack == {1'b0, seq_number} && final_sent) begin
            act = ACT_END;
          end else begin
            act = ACT_RESTART;
          end
        end
        PH_ENDING: begin
          if (q_head.sub != SUB_END) begin
            act       = ACT_ABORT;
            ab_reason = AR_BAD_CMD;
          end else begin
            act = ACT_FINISH;
          end
        end
        default: act = ACT_NONE;
      endcase
    end
  end

  // Next state.
  always_comb begin
    phase_next          = phase;
    total_size_next     = total_size;
    next_offset_next    = next_offset;
    block_base_next     = block_base;
    seq_number_next     = seq_number;
    segs_per_block_next = segs_per_block;
    final_sent_next     = final_sent;
    crc_flag_next       = crc_flag;
    case (act)
      ACT_SEGMENT: begin
        next_offset_next = off_after;
        final_sent_next  = seg_last;
        if (seg_last || seq_number == segs_per_block) begin
          phase_next = PH_AWAIT_ACK;
        end else begin
          seq_number_next = seq_number + 7'd1;
        end
      end
      ACT_INIT: begin
        crc_flag_next       = q_head.crc;
        segs_per_block_next = q_head.blksize;
        total_size_next     = q_head.obj_size;
        next_offset_next    = '0;
        block_base_next     = '0;
        seq_number_next     = 7'd1;
        final_sent_next     = 1'b0;
        phase_next          = PH_READY;
      end
      ACT_START: phase_next = PH_SENDING;
      ACT_END:   phase_next = PH_ENDING;
      ACT_RESTART: begin
        next_offset_next    = restart_offset;
        block_base_next     = restart_offset;
        segs_per_block_next = q_head.blksize;
        seq_number_next     = 7'd1;
        final_sent_next     = 1'b0;
        phase_next          = PH_SENDING;
      end
      ACT_FINISH, ACT_ABORT: begin
        phase_next          = PH_IDLE;
        total_size_next     = '0;
        next_offset_next    = '0;
        block_base_next     = '0;
        seq_number_next     = 7'd1;
        segs_per_block_next = '0;
        final_sent_next     = 1'b0;
        crc_flag_next       = 1'b0;
      end
      default: phase_next = phase;
    endcase
  end

  // Result of the transaction at the queue head.
  always_comb begin
    res_next      = '0;
    res_next.kind = FK_NONE;
    case (act)
      ACT_SEGMENT: begin
        res_next.kind   = FK_SEGMENT;
        res_next.seq    = seq_number;
        res_next.offset = next_offset;
        res_next.length = seg_len[2:0];
        res_next.last   = seg_last;
      end
      ACT_INIT: begin
        res_next.kind   = FK_INIT;
        res_next.crc_on = q_head.crc;
        res_next.size   = q_head.obj_size;
      end
      ACT_END: begin
        res_next.kind   = FK_END;
        res_next.unused = 3'(SEG_LEN - last_len);
        res_next.crc_on = crc_flag;
      end
      ACT_FINISH: res_next.finished = 1'b1;
      ACT_ABORT: begin
        res_next.kind    = FK_ABORT;
        res_next.reason  = ab_reason;
        res_next.obj_err = ab_err;
      end
      default: res_next.kind = FK_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      total_size     <= '0;
      next_offset    <= '0;
      block_base     <= '0;
      seq_number     <= 7'd1;
      segs_per_block <= '0;
      final_sent     <= 1'b0;
      crc_flag       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        phase          <= phase_next;
        total_size     <= total_size_next;
        next_offset    <= next_offset_next;
        block_base     <= block_base_next;
        seq_number     <= seq_number_next;
        segs_per_block <= segs_per_block_next;
        final_sent     <= final_sent_next;
        crc_flag       <= crc_flag_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Block offsets stay multiples of the segment size, so the length of the
  // final segment sent is the length the end frame reports against.
  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
      if (act == ACT_SEGMENT && seg_last) last_len <= seg_len;
    end
  end

endmodule

// ----- rtl/sdobu_checker.sv -----
// Port-level checks of the block upload server, bound to its top level.
`include "sdo_block_upload_server_unit_assert.svh"

module sdobu_checker import sdobu_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  frame_kind,
  input logic [6:0]  sequence_res,
  input logic        last_segment,
  input logic [31:0] data_offset,
  input logic [2:0]  data_length,
  input logic [2:0]  abort_reason,
  input logic [3:0]  object_error,
  input logic        finished
);

  // A stalled result holds.
  `SDOBU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frame_kind) && $stable(data_offset))

  // Segment fields are zero on every other kind of transaction.
  `SDOBU_ASSERT_IMPLIES(a_seg_fields, out_valid && frame_kind != FK_SEGMENT, sequence_res == 7'd0 && data_length == 3'd0 && data_offset == 32'd0 && !last_segment)

  // An abort always carries a reason.
  `SDOBU_ASSERT_IMPLIES(a_abort_reason, out_valid && frame_kind == FK_ABORT, abort_reason != AR_NONE)

  // An error index only comes with an object error abort.
  `SDOBU_ASSERT_IMPLIES(a_obj_err, out_valid && abort_reason != AR_OBJECT, object_error == 4'd0)

  // The finish indication sends no frame.
  `SDOBU_ASSERT_IMPLIES(a_finish_quiet, out_valid && finished, frame_kind == FK_NONE)

endmodule

bind sdo_block_upload_server_unit sdobu_checker u_sdobu_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the block upload server unit.
module testbench;
  import sdobu_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic        func;
    subcmd_t     sub;
    logic [7:0]  bsz;
    logic [7:0]  ack;
    logic        crc;
    logic [3:0]  ostat;
    logic [31:0] osize;
    logic [3:0]  rstat;
  } upload_item_t;

  typedef struct packed {
    frame_kind_t   kind;
    logic [6:0]    seq;
    logic          last;
    logic [31:0]   offset;
    logic [2:0]    length;
    logic [2:0]    unused;
    logic          crc;
    logic [31:0]   xfer_size;
    abort_reason_t reason;
    logic [3:0]    err;
    logic          done;
  } server_frame_t;

  typedef struct packed {
    upload_item_t  stim;
    logic          typed;
    frame_kind_t   kind;
    logic          crc;
    logic [31:0]   xfer_size;
    abort_reason_t reason;
    logic [3:0]    err;
  } directed_row_t;

  typedef struct packed {
    logic          typed;
    server_frame_t frame;
  } typed_frame_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        func;
  logic [1:0]  client_subcommand;
  logic [7:0]  block_size;
  logic [7:0]  ack_sequence;
  logic        crc_supported;
  logic [3:0]  object_status;
  logic [31:0] object_size;
  logic [3:0]  read_status;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  frame_kind;
  logic [6:0]  sequence_res;
  logic        last_segment;
  logic [31:0] data_offset;
  logic [2:0]  data_length;
  logic [2:0]  unused_bytes;
  logic        crc_on;
  logic [31:0] transfer_size;
  logic [2:0]  abort_reason;
  logic [3:0]  object_error;
  logic        finished;

  sdo_block_upload_server_unit dut (.*);

  // Transfer state as the server should hold it.
  phase_t      xfer_phase;
  logic [31:0] obj_size;
  logic [31:0] cur_offset;
  logic [31:0] blk_base;
  logic [6:0]  seq_no;
  logic [6:0]  blk_segs;
  logic        final_out;
  logic        crc_en;

  server_frame_t pending_frames[$];
  typed_frame_t  typed_rows[$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  bit            quiet = 0;
  bit            flood = 0;

  // Rows with a typed expectation are checked against that value; the rest
  // are checked against the predictor.
  directed_row_t directed_rows [0:22] = '{
    '{'{1'b1, SUB_INITIATE, 8'd0,   8'd0,   1'b0, 4'd0,  32'd0,          4'd0},
      1'b1, FK_NONE, 1'b0, 32'd0, AR_NONE, 4'd0},
    '{'{1'b0, SUB_END,      8'd8,   8'd0,   1'b1, 4'd5,  32'd100,        4'd0},
      1'b1, FK_ABORT, 1'b0, 32'd0, AR_BAD_CMD, 4'd0},
    '{'{1'b0, SUB_INITIATE, 8'd0,   8'd0,   1'b1, 4'd15, 32'd10,         4'd0},
      1'b1, FK_ABORT, 1'b0, 32'd0, AR_OBJECT, 4'd15},
    '{'{1'b0, SUB_INITIATE, 8'd0,   8'd0,   1'b0, 4'd0,  32'd10,         4'd0},
      1'b1, FK_ABORT, 1'b0, 32'd0, AR_BAD_BLKSIZE, 4'd0},
    '{'{1'b0, SUB_INITIATE, 8'd128, 8'd0,   1'b0, 4'd0,  32'd10,         4'd0},
      1'b1, FK_ABORT, 1'b0, 32'd0, AR_BAD_BLKSIZE, 4'd0},
    '{'{1'b0, SUB_INITIATE, 8'd255, 8'd255, 1'b1, 4'd0,  32'hFFFF_FFFF,  4'd15},
      1'b1, FK_ABORT, 1'b0, 32'd0, AR_BAD_BLKSIZE, 4'd0},
    '{'{1'b0, SUB_INITIATE, 8'd127, 8'd0,   1'b1, 4'd0,  32'd0,          4'd0},
      1'b1, FK_INIT, 1'b1, 32'd0, AR_NONE, 4'd0},
    '{'{1'b1, SUB_INITIATE, 8'd0,   8'd0,   1'b0, 4'd0,  32'd0,          4'd15},
      1'b1, FK_NONE, 1'b0, 32'd0, AR_NONE, 4'd0},
    '{'{1'b0, SUB_START,    8'd0,   8'd0,   1'b0, 4'd0,  32'd0,          4'd0},
      1'b1, FK_NONE, 1'b0, 32'd0, AR_NONE, 4'd0},
    '{'{1'b1, SUB_INITIATE, 8'd0,   8'd0,   1'b0, 4'd0,  32'd0,          4'd0},
      1'b0, FK_NONE, 1'b0, 32'd0, AR_NONE, 4'd0},
    '{'{1'b0, SUB_RESPONSE, 8'd1,   8'd1,   1'b0, 4'd0,  32'd0,          4'd0},
      1'b0, FK_NONE, 1'b0, 32'd0, AR_NONE, 4'd0},
    '{'{1'b0, SUB_END,      8'd0,   8'd0,   1'b0, 4'd0,  32'd0,          4'd0},
      1'b0, FK_NONE, 1'b0, 32'd0, AR_NONE, 4'd0},
    '{'{1'b0, SUB_INITIATE, 8'd1,   8'd0,   1'b0, 4'd0,  32'hFFFF_FFFF,  4'd0},
      1'b1, FK_INIT, 1'b0, 32'hFFFF_FFFF, AR_NONE, 4'd0},
    '{'{1'b0, SUB_START,    8'd0,   8'd0,   1'b0, 4'd0,  32'd0,          4'd0},
      1'b1, FK_NONE, 1'b0, 32'd0, AR_NONE, 4'd0},
    '{'{1'b1, SUB_INITIATE, 8'd0,   8'd0,   1'b0, 4'd0,  32'd0,          4'd0},
      1'b0, FK_NONE, 1'b0, 32'd0, AR_NONE, 4'd0},
    '{'{1'b0, SUB_RESPONSE, 8'd1,   8'd255, 1'b0, 4'd0,  32'd0,          4'd0},
      1'b1, FK_ABORT, 1'b0, 32'd0, AR_BAD_SEQ, 4'd0},
    '{'{1'b0, SUB_INITIATE, 8'd2,   8'd0,   1'b1, 4'd0,  32'd20,         4'd0},
      1'b1, FK_INIT, 1'b1, 32'd20, AR_NONE, 4'd0},
    '{'{1'b0, SUB_START,    8'd0,   8'd0,   1'b0, 4'd0,  32'd0,          4'd0},
      1'b1, FK_NONE, 1'b0, 32'd0, AR_NONE, 4'd0},
    '{'{1'b1, SUB_INITIATE, 8'd0,   8'd0,   1'b0, 4'd0,  32'd0,          4'd0},
      1'b0, FK_NONE, 1'b0, 32'd0, AR_NONE, 4'd0},
    '{'{1'b0, SUB_END,      8'd0,   8'd0,   1'b0, 4'd0,  32'd0,          4'd0},
      1'b1, FK_NONE, 1'b0, 32'd0, AR_NONE, 4'd0},
    '{'{1'b1, SUB_INITIATE, 8'd0,   8'd0,   1'b0, 4'd0,  32'd0,          4'd0},
      1'b0, FK_NONE, 1'b0, 32'd0, AR_NONE, 4'd0},
    '{'{1'b0, SUB_RESPONSE, 8'd127, 8'd0,   1'b0, 4'd0,  32'd0,          4'd0},
      1'b0, FK_NONE, 1'b0, 32'd0, AR_NONE, 4'd0},
    '{'{1'b1, SUB_INITIATE, 8'd0,   8'd0,   1'b0, 4'd0,  32'd0,          4'd15},
      1'b1, FK_ABORT, 1'b0, 32'd0, AR_OBJECT, 4'd15}
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_transfer();
    xfer_phase = PH_IDLE;
    obj_size   = '0;
    cur_offset = '0;
    blk_base   = '0;
    seq_no     = 7'd1;
    blk_segs   = '0;
    final_out  = 1'b0;
    crc_en     = 1'b0;
  endfunction

  function automatic server_frame_t abort_frame(abort_reason_t why, logic [3:0] err);
    server_frame_t r;
    r = '0;
    clear_transfer();
    r.kind   = FK_ABORT;
    r.reason = why;
    r.err    = err;
    return r;
  endfunction

  function automatic server_frame_t predict_server_frame(upload_item_t it);
    server_frame_t r;
    logic [31:0]   remaining;
    logic [31:0]   len;
    logic [31:0]   last_len;
    r = '0;
    if (it.func) begin
      if (xfer_phase != PH_SENDING) return r;
      if (it.rstat != 4'd0) return abort_frame(AR_OBJECT, it.rstat);
      remaining  = obj_size - cur_offset;
      len        = (remaining < SEGMENT_BYTES) ? remaining : SEGMENT_BYTES;
      r.kind     = FK_SEGMENT;
      r.seq      = seq_no;
      r.offset   = cur_offset;
      r.length   = len[2:0];
      cur_offset = cur_offset + len;
      r.last     = (cur_offset == obj_size);
      final_out  = r.last;
      if (r.last || seq_no == blk_segs) xfer_phase = PH_AWAIT_ACK;
      else seq_no = seq_no + 7'd1;
      return r;
    end
    case (xfer_phase)
      PH_IDLE: begin
        if (it.sub != SUB_INITIATE) return abort_frame(AR_BAD_CMD, 4'd0);
        if (it.ostat != 4'd0) return abort_frame(AR_OBJECT, it.ostat);
        if (it.bsz < 8'd1 || it.bsz > 8'(MAX_SEQ)) return abort_frame(AR_BAD_BLKSIZE, 4'd0);
        crc_en      = it.crc;
        blk_segs    = it.bsz[6:0];
        obj_size    = it.osize;
        cur_offset  = '0;
        blk_base    = '0;
        seq_no      = 7'd1;
        final_out   = 1'b0;
        xfer_phase  = PH_READY;
        r.kind      = FK_INIT;
        r.crc       = crc_en;
        r.xfer_size = obj_size;
      end
      PH_READY: begin
        if (it.sub != SUB_START) return abort_frame(AR_BAD_CMD, 4'd0);
        xfer_phase = PH_SENDING;
      end
      PH_AWAIT_ACK: begin
        if (it.sub != SUB_RESPONSE) return abort_frame(AR_BAD_CMD, 4'd0);
        if (it.bsz < 8'd1 || it.bsz > 8'(MAX_SEQ)) return abort_frame(AR_BAD_BLKSIZE, 4'd0);
        if (it.ack > {1'b0, seq_no}) return abort_frame(AR_BAD_SEQ, 4'd0);
        if (it.ack == {1'b0, seq_no} && final_out) begin
          last_len   = (obj_size == 0) ? 32'd0 : ((obj_size - 1) % SEGMENT_BYTES) + 1;
          r.kind     = FK_END;
          r.unused   = 3'(SEGMENT_BYTES - last_len);
          r.crc      = crc_en;
          xfer_phase = PH_ENDING;
          return r;
        end
        // The client asks for a new block from the first unacknowledged segment.
        cur_offset = blk_base + 32'(it.ack) * 32'(SEGMENT_BYTES);
        blk_base   = cur_offset;
        blk_segs   = it.bsz[6:0];
        seq_no     = 7'd1;
        final_out  = 1'b0;
        xfer_phase = PH_SENDING;
      end
      PH_ENDING: begin
        if (it.sub != SUB_END) return abort_frame(AR_BAD_CMD, 4'd0);
        clear_transfer();
        r.done = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly well-formed transfers driven by the current phase, with some noise.
  function automatic upload_item_t draw_item();
    upload_item_t it;
    it.func  = 1'($urandom_range(0, 1));
    it.sub   = subcmd_t'($urandom_range(0, 3));
    it.bsz   = 8'($urandom);
    it.ack   = 8'($urandom);
    it.crc   = 1'($urandom_range(0, 1));
    it.ostat = 4'($urandom);
    it.osize = $urandom();
    it.rstat = 4'($urandom);
    if ($urandom_range(0, 99) < 8) return it;
    it.func = 1'b0;
    case (xfer_phase)
      PH_IDLE: begin
        it.sub   = ($urandom_range(0, 99) < 96) ? SUB_INITIATE : it.sub;
        it.ostat = ($urandom_range(0, 99) < 6) ? 4'($urandom_range(1, 15)) : 4'd0;
        if ($urandom_range(0, 99) < 6) it.bsz = ($urandom_range(0, 1) == 0) ? 8'd0 : it.bsz | 8'h80;
        else if ($urandom_range(0, 99) < 65) it.bsz = 8'($urandom_range(1, 8));
        else it.bsz = 8'($urandom_range(1, MAX_SEQ));
        if ($urandom_range(0, 99) < 88) it.osize = $urandom_range(0, 60);
      end
      PH_READY: begin
        if ($urandom_range(0, 99) < 95) it.sub = SUB_START;
      end
      PH_SENDING: begin
        if ($urandom_range(0, 99) < 95) begin
          it.func  = 1'b1;
          it.rstat = ($urandom_range(0, 99) < 98) ? 4'd0 : 4'($urandom_range(1, 15));
        end
      end
      PH_AWAIT_ACK: begin
        if ($urandom_range(0, 99) < 97) it.sub = SUB_RESPONSE;
        if ($urandom_range(0, 99) < 5) it.bsz = ($urandom_range(0, 1) == 0) ? 8'd0 : it.bsz | 8'h80;
        else if ($urandom_range(0, 99) < 60) it.bsz = 8'($urandom_range(1, 8));
        else it.bsz = 8'($urandom_range(1, MAX_SEQ));
        if ($urandom_range(0, 99) < 70) it.ack = {1'b0, seq_no};
        else if ($urandom_range(0, 99) < 75) it.ack = 8'($urandom_range(0, int'(seq_no)));
        else it.ack = 8'($urandom_range(int'(seq_no) + 1, 255));
      end
      PH_ENDING: begin
        if ($urandom_range(0, 99) < 95) it.sub = SUB_END;
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic offer_item(upload_item_t it);
    int gap;
    gap = (quiet || flood) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func              <= it.func;
    client_subcommand <= it.sub;
    block_size        <= it.bsz;
    ack_sequence      <= it.ack;
    crc_supported     <= it.crc;
    object_status     <= it.ostat;
    object_size       <= it.osize;
    read_status       <= it.rstat;
    in_valid          <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic compare_frame(server_frame_t want, server_frame_t got);
    if (got.kind !== want.kind) begin
      $error("frame_kind: expected %0d, got %0d", want.kind, got.kind);
      mismatches++;
    end
    if (got.seq !== want.seq) begin
      $error("sequence_res: expected %0d, got %0d", want.seq, got.seq);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last_segment: expected %0d, got %0d", want.last, got.last);
      mismatches++;
    end
    if (got.offset !== want.offset) begin
      $error("data_offset: expected %0h, got %0h", want.offset, got.offset);
      mismatches++;
    end
    if (got.length !== want.length) begin
      $error("data_length: expected %0d, got %0d", want.length, got.length);
      mismatches++;
    end
    if (got.unused !== want.unused) begin
      $error("unused_bytes: expected %0d, got %0d", want.unused, got.unused);
      mismatches++;
    end
    if (got.crc !== want.crc) begin
      $error("crc_on: expected %0d, got %0d", want.crc, got.crc);
      mismatches++;
    end
    if (got.xfer_size !== want.xfer_size) begin
      $error("transfer_size: expected %0h, got %0h", want.xfer_size, got.xfer_size);
      mismatches++;
    end
    if (got.reason !== want.reason) begin
      $error("abort_reason: expected %0d, got %0d", want.reason, got.reason);
      mismatches++;
    end
    if (got.err !== want.err) begin
      $error("object_error: expected %0d, got %0d", want.err, got.err);
      mismatches++;
    end
    if (got.done !== want.done) begin
      $error("finished: expected %0d, got %0d", want.done, got.done);
      mismatches++;
    end
  endtask

  // Results are registered, so a result never belongs to the transaction
  // taken at the same edge; checking before predicting keeps the order.
  always @(posedge clk) begin
    server_frame_t got;
    server_frame_t want;
    upload_item_t  taken;
    typed_frame_t  row;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.kind      = frame_kind_t'(frame_kind);
        got.seq       = sequence_res;
        got.last      = last_segment;
        got.offset    = data_offset;
        got.length    = data_length;
        got.unused    = unused_bytes;
        got.crc       = crc_on;
        got.xfer_size = transfer_size;
        got.reason    = abort_reason_t'(abort_reason);
        got.err       = object_error;
        got.done      = finished;
        if (pending_frames.size() == 0) begin
          $error("result with no transaction waiting for it");
          mismatches++;
        end else begin
          want = pending_frames.pop_front();
          compare_frame(want, got);
        end
      end
      if (in_valid && in_ready) begin
        taken = {func, subcmd_t'(client_subcommand), block_size, ack_sequence,
                 crc_supported, object_status, object_size, read_status};
        want = predict_server_frame(taken);
        if (typed_rows.size() != 0) begin
          row = typed_rows.pop_front();
          if (row.typed) want = row.frame;
        end
        pending_frames.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random back-pressure, plus one long hold that fills the queue.
  initial begin
    int  stall;
    int  results_taken;
    bit  held;
    results_taken = 0;
    held          = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && results_taken == 400) begin
        held = 1;
        flood = 1;
        out_ready <= 1'b0;
        repeat (150) @(negedge clk);
        flood = 0;
      end else begin
        stall = (quiet || flood) ? 0 : $urandom_range(0, 19);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
      @(negedge clk);
    end
  end

  initial begin
    typed_frame_t row;
    rst               = 1'b1;
    clk               = 1'b0;
    in_valid          = 1'b0;
    out_ready         = 1'b0;
    func              = 1'b0;
    client_subcommand = '0;
    block_size        = '0;
    ack_sequence      = '0;
    crc_supported     = 1'b0;
    object_status     = '0;
    object_size       = '0;
    read_status       = '0;
    clear_transfer();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row.typed           = directed_rows[i].typed;
      row.frame           = '0;
      row.frame.kind      = directed_rows[i].kind;
      row.frame.crc       = directed_rows[i].crc;
      row.frame.xfer_size = directed_rows[i].xfer_size;
      row.frame.reason    = directed_rows[i].reason;
      row.frame.err       = directed_rows[i].err;
      typed_rows.push_back(row);
      offer_item(directed_rows[i].stim);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = ((n / 120) % 4) == 3;
      offer_item(draw_item());
    end
    quiet = 0;
    in_valid <= 1'b0;

    while (pending_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sdobu_pkg.sv
rtl/sdobu_front.sv
rtl/sdobu_queue.sv
rtl/sdobu_back.sv
rtl/sdo_block_upload_server_unit.sv
rtl/sdobu_checker.sv
tb/testbench.sv
